FILE: rtl/assert_macros.svh
// Assertion macros used by the ordered list store RTL.
// Needs signals clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define OLSE_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("olse: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define OLSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olse: assertion failed");

`endif

FILE: rtl/olse_pkg.sv
// Ordered list store: field widths and request function codes.
// No dependencies.
package olse_pkg;

  localparam int FUNC_W = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 9;

  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd4;

endpackage

FILE: rtl/olse_req_if.sv
// Request channel of the ordered list store: valid/ready plus request fields.
// Depends on olse_pkg.
interface olse_req_if;
  import olse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [VAL_W-1:0]  element_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output func, output element_value, output position,
                  input ready);
  modport sink   (input valid, input func, input element_value, input position,
                  output ready);
endinterface

FILE: rtl/olse_rsp_if.sv
// Response channel of the ordered list store: valid/ready plus result fields.
// Depends on olse_pkg.
interface olse_rsp_if;
  import olse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  result_value;
  logic [POS_W-1:0]         result_position;
  logic                     found;
  logic [POS_W-1:0]         element_count;

  modport source (output valid, output result_value, output result_position,
                  output found, output element_count, input ready);
  modport sink   (input valid, input result_value, input result_position,
                  input found, input element_count, output ready);
endinterface

FILE: rtl/ordered_list_store_engine_core.sv
// Ordered list store engine, top level: an ordered list of signed 32-bit values
// in one RAM of CAPACITY entries, with a sequencer that walks it.
// Depends on olse_pkg, olse_req_if, olse_rsp_if, olse_ram, assert_macros.svh.
//
// Usage:
//   req carries one request per transfer: func, element_value, position.
//   rsp returns exactly one result per request, in order, with the element
//   count after the request.
//   One request is in work at a time; req.ready is high while the sequencer
//   is idle, also while a finished result still waits in the output register.
//   Sequencer work between request transfer and rsp.valid:
//     append, refused requests, unused codes: no RAM read
//     read: one RAM fetch
//     delete at p: count - p moved entries (one RAM read and write per moved entry)
//     find / next after key: scan from entry 0 up to the first match, then one
//     more fetch for next; a miss scans all count entries.
//   The worst case is set by the single RAM read port visiting one entry per
//   cycle.
//   When rsp is stalled the result holds in the output register; a following
//   request is taken and worked, and waits at its end for the register.
//   Reset empties the list at once; RAM contents are not cleared, since only
//   entries below the count are ever read.
`include "assert_macros.svh"

module ordered_list_store_engine_core #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  olse_req_if.sink    req,
  olse_rsp_if.source  rsp
);
  import olse_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]              state, state_next;
  logic [LW-1:0]           len, len_next;
  logic [FUNC_W-1:0]       func_q, func_q_next;
  logic signed [VAL_W-1:0] key, key_next;
  logic [AW-1:0]           scan, scan_next;
  logic [VAL_W-1:0]        rval, rval_next;
  logic [POS_W-1:0]        rpos, rpos_next;
  logic                    hit, hit_next;

  logic                    out_valid, out_valid_next;
  logic [VAL_W-1:0]        out_value;
  logic [POS_W-1:0]        out_position;
  logic                    out_found;
  logic [POS_W-1:0]        out_count;
  logic                    out_load;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;

  logic                    req_xfer;
  logic [CW-1:0]           pos_wide;
  logic [CW-1:0]           len_wide;
  logic                    pos_ok;
  logic [LW-1:0]           scan_inc;
  logic                    scan_more;

  olse_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && (state == S_IDLE);

  assign pos_wide  = CW'(req.position);
  assign len_wide  = CW'(len);
  assign pos_ok    = (req.position != '0) && (pos_wide <= len_wide);
  assign scan_inc  = LW'(scan) + LW'(1);
  assign scan_more = scan_inc < len;

  always_comb begin
    state_next     = state;
    len_next       = len;
    func_q_next    = func_q;
    key_next       = key;
    scan_next      = scan;
    rval_next      = rval;
    rpos_next      = rpos;
    hit_next       = hit;
    ram_we         = 1'b0;
    ram_waddr      = scan;
    ram_wdata      = ram_rdata;
    ram_raddr      = scan;
    out_load       = 1'b0;
    out_valid_next = out_valid && !rsp.ready;

    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          func_q_next = req.func;
          key_next    = req.element_value;
          rval_next   = '0;
          rpos_next   = '0;
          hit_next    = 1'b0;
          state_next  = S_DONE;
          case (req.func)
            FN_APPEND: begin
              if (len < LW'(CAPACITY)) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(len);
                ram_wdata = req.element_value;
                len_next  = len + LW'(1);
                hit_next  = 1'b1;
              end
            end
            FN_DELETE: begin
              if (pos_ok) begin
                hit_next = 1'b1;
                if (pos_wide < len_wide) begin
                  ram_raddr  = AW'(pos_wide);
                  scan_next  = AW'(pos_wide);
                  state_next = S_SHIFT;
                end else begin
                  len_next = len - LW'(1);
                end
              end
            end
            FN_READ: begin
              if (pos_ok) begin
                ram_raddr  = AW'(pos_wide - CW'(1));
                state_next = S_FETCH;
              end
            end
            FN_FIND, FN_NEXT: begin
              if (len != '0) begin
                ram_raddr  = '0;
                scan_next  = '0;
                state_next = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = scan - AW'(1);
        ram_wdata = ram_rdata;
        if (scan_more) begin
          ram_raddr = AW'(scan_inc);
          scan_next = AW'(scan_inc);
        end else begin
          len_next   = len - LW'(1);
          state_next = S_DONE;
        end
      end
      S_SEARCH: begin
        if (ram_rdata == key) begin
          if (func_q == FN_FIND) begin
            hit_next   = 1'b1;
            rpos_next  = POS_W'(scan_inc);
            state_next = S_DONE;
          end else if (scan_more) begin
            ram_raddr  = AW'(scan_inc);
            state_next = S_FETCH;
          end else begin
            state_next = S_DONE;
          end
        end else if (scan_more) begin
          ram_raddr = AW'(scan_inc);
          scan_next = AW'(scan_inc);
        end else begin
          state_next = S_DONE;
        end
      end
      S_FETCH: begin
        rval_next  = ram_rdata;
        hit_next   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    func_q <= func_q_next;
    key    <= key_next;
    scan   <= scan_next;
    rval   <= rval_next;
    rpos   <= rpos_next;
    hit    <= hit_next;
    if (out_load) begin
      out_value    <= rval;
      out_position <= rpos;
      out_found    <= hit;
      out_count    <= POS_W'(len);
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.result_value    = out_value;
  assign rsp.result_position = out_position;
  assign rsp.found           = out_found;
  assign rsp.element_count   = out_count;

  `OLSE_ASSERT(a_len_bound, len <= LW'(CAPACITY))
  `OLSE_ASSERT(a_write_in_list, !ram_we || (LW'(ram_waddr) <= len))
  `OLSE_ASSERT_NEXT(a_append_grows,
    req_xfer && (req.func == FN_APPEND) && (len < LW'(CAPACITY)),
    len == $past(len) + LW'(1))
  `OLSE_ASSERT(a_shift_nonempty, (state != S_SHIFT) || ((scan != '0) && (len != '0)))

endmodule

FILE: rtl/olse_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module olse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: tb/ordered_list_store_engine_core_tb.sv
// Testbench for ordered_list_store_engine_core: directed and random list requests,
// each result checked against a cycle-free model of the list held in the bench.
// Depends on olse_pkg, olse_req_if, olse_rsp_if and the engine RTL.
module ordered_list_store_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import olse_pkg::*;

  localparam int LIST_DEPTH  = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_REQS = 150;
  localparam logic [FUNC_W-1:0] FN_TOP_CODE = '1;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_TOP = '1;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    logic                    found;
    logic [POS_W-1:0]        count;
  } list_result_t;

  logic clk;
  logic rst;

  olse_req_if req_ch();
  olse_rsp_if rsp_ch();

  ordered_list_store_engine_core #(.CAPACITY(LIST_DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic signed [VAL_W-1:0] list_model [LIST_DEPTH];
  int           list_len;
  list_result_t expected_results [$];
  int           error_count;
  int           req_count;
  int           rsp_count;
  int           peak_len;
  int           func_count [8];
  int           hold_req;
  bit           hold_active;
  bit           sender_gaps_on;
  int           burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic list_result_t predict_list_op(input logic [FUNC_W-1:0] f,
                                                   input logic signed [VAL_W-1:0] v,
                                                   input logic [POS_W-1:0] p);
    list_result_t r;
    int hit;
    int pi;
    r = '0;
    hit = -1;
    pi = int'(p);
    if (f == FN_FIND || f == FN_NEXT) begin
      for (int i = 0; i < list_len && hit < 0; i++) begin
        if (list_model[i] == v) hit = i;
      end
    end
    case (f)
      FN_APPEND: begin
        if (list_len < LIST_DEPTH) begin
          list_model[list_len] = v;
          list_len++;
          r.found = 1'b1;
        end
      end
      FN_DELETE: begin
        if (pi >= 1 && pi <= list_len) begin
          for (int i = pi - 1; i < list_len - 1; i++) list_model[i] = list_model[i + 1];
          list_len--;
          r.found = 1'b1;
        end
      end
      FN_READ: begin
        if (pi >= 1 && pi <= list_len) begin
          r.value = list_model[pi - 1];
          r.found = 1'b1;
        end
      end
      FN_FIND: begin
        if (hit >= 0) begin
          r.pos   = POS_W'(hit + 1);
          r.found = 1'b1;
        end
      end
      FN_NEXT: begin
        if (hit >= 0 && hit + 1 < list_len) begin
          r.value = list_model[hit + 1];
          r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = POS_W'(list_len);
    return r;
  endfunction

  // small pool gives duplicate keys; otherwise full range or extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $signed($urandom_range(0, 7)) - 4;
    if (roll < 9) return $urandom;
    return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
  endfunction

  task automatic send_req(input logic [FUNC_W-1:0] f, input logic signed [VAL_W-1:0] v,
                          input logic [POS_W-1:0] p);
    int gap;
    req_ch.valid         <= 1'b1;
    req_ch.func          <= f;
    req_ch.element_value <= v;
    req_ch.position      <= p;
    do @(posedge clk); while (!req_ch.ready);
    expected_results.push_back(predict_list_op(f, v, p));
    req_count++;
    func_count[f]++;
    if (list_len > peak_len) peak_len = list_len;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_count++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transfer value=%0d pos=%0d found=%0b count=%0d", $time,
                 rsp_ch.result_value, rsp_ch.result_position, rsp_ch.found,
                 rsp_ch.element_count);
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp_ch.result_value !== exp_r.value) begin
          error_count++;
          $display("%0t: result_value expected %0d actual %0d", $time, exp_r.value,
                   rsp_ch.result_value);
        end
        if (rsp_ch.result_position !== exp_r.pos) begin
          error_count++;
          $display("%0t: result_position expected %0d actual %0d", $time, exp_r.pos,
                   rsp_ch.result_position);
        end
        if (rsp_ch.found !== exp_r.found) begin
          error_count++;
          $display("%0t: found expected %0b actual %0b", $time, exp_r.found, rsp_ch.found);
        end
        if (rsp_ch.element_count !== exp_r.count) begin
          error_count++;
          $display("%0t: element_count expected %0d actual %0d", $time, exp_r.count,
                   rsp_ch.element_count);
        end
      end
    end
  end

  initial begin : receiver
    rx_mode_e mode;
    int mode_left;
    int hold_left;
    int phase;
    mode = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
        hold_active = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
        if (hold_left == 0) hold_active = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_ALWAYS:   rsp_ch.ready <= 1'b1;
          RX_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 9) < 7);
          RX_PERIODIC: rsp_ch.ready <= ((phase % 7) < 4);
          default:     rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles, %0d results outstanding", STALL_LIMIT,
             expected_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  task automatic test_empty_list();
    send_req(FN_READ, '0, POS_W'(1));
    send_req(FN_DELETE, '0, POS_W'(1));
    send_req(FN_FIND, '0, '0);
    send_req(FN_NEXT, '0, '0);
  endtask

  task automatic test_ends_and_keys();
    send_req(FN_APPEND, VAL_MIN, '0);
    send_req(FN_APPEND, VAL_MAX, POS_TOP);
    send_req(FN_APPEND, -1, '0);
    send_req(FN_APPEND, '0, '0);
    send_req(FN_APPEND, VAL_MAX, '0);
    send_req(FN_FIND, VAL_MAX, '0);
    send_req(FN_NEXT, VAL_MIN, '0);
    send_req(FN_NEXT, '0, '0);
    send_req(FN_NEXT, VAL_MAX, '0);
    send_req(FN_FIND, 7, '0);
    send_req(FN_NEXT, 7, '0);
    send_req(FN_READ, '0, '0);
    send_req(FN_READ, '0, POS_W'(5));
    send_req(FN_READ, '0, POS_W'(6));
    send_req(FN_READ, '0, POS_TOP);
    send_req(FN_DELETE, '0, '0);
    send_req(FN_DELETE, '0, POS_W'(6));
    send_req(FN_DELETE, '0, POS_W'(2));
    send_req(FN_READ, '0, POS_W'(2));
    send_req(FN_DELETE, '0, POS_W'(4));
    // 0 now sits in last place
    send_req(FN_NEXT, '0, '0);
  endtask

  task automatic test_unused_codes();
    for (int f = FN_NEXT + 1; f <= FN_TOP_CODE; f++) begin
      send_req(FUNC_W'(f), $urandom, POS_W'($urandom_range(0, POS_TOP)));
    end
  endtask

  task automatic test_full_store();
    while (list_len < LIST_DEPTH) send_req(FN_APPEND, $urandom, '0);
    send_req(FN_APPEND, '0, '0);
    send_req(FN_APPEND, $urandom, '0);
    send_req(FN_READ, '0, POS_W'(LIST_DEPTH));
    send_req(FN_READ, '0, POS_W'(LIST_DEPTH + 1));
    send_req(FN_FIND, list_model[LIST_DEPTH - 1], '0);
    send_req(FN_NEXT, list_model[LIST_DEPTH - 2], '0);
    send_req(FN_NEXT, list_model[LIST_DEPTH - 1], '0);
    send_req(FN_FIND, $urandom, '0);
    send_req(FN_DELETE, '0, POS_W'(1));
    send_req(FN_DELETE, '0, POS_W'(list_len));
    while (list_len > 0) begin
      case ($urandom_range(0, 7))
        0:       send_req(FN_FIND, list_model[$urandom_range(0, list_len - 1)], '0);
        1:       send_req(FN_READ, '0, POS_W'($urandom_range(1, list_len)));
        default: send_req(FN_DELETE, '0, POS_W'($urandom_range(1, list_len)));
      endcase
    end
  endtask

  task automatic test_output_backpressure();
    req_ch.valid <= 1'b0;
    hold_req = HOLD_CYCLES;
    wait (hold_active);
    sender_gaps_on = 1'b0;
    for (int n = 0; n < 16; n++) begin
      if (n % 2 == 0) send_req(FN_APPEND, pick_value(), '0);
      else send_req(FN_READ, '0, POS_W'($urandom_range(1, list_len)));
    end
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int target;
    int pick;
    int roll;
    bit grow;
    logic [FUNC_W-1:0] f;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    target = 0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 100 == 0) sender_gaps_on = ($urandom_range(0, 3) != 0);
      if (n % 60 == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) target = $urandom_range(0, 12);
        else if (roll < 95) target = $urandom_range(13, 64);
        else target = $urandom_range(65, LIST_DEPTH);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        f = FUNC_W'($urandom_range(FN_NEXT + 1, FN_TOP_CODE));
        v = $urandom;
        p = POS_W'($urandom_range(0, POS_TOP));
      end else if (pick < 8) begin
        f = FUNC_W'($urandom_range(FN_APPEND, FN_NEXT));
        v = $urandom;
        p = POS_W'($urandom_range(0, POS_TOP));
      end else begin
        grow = (list_len < target);
        pick = $urandom_range(0, 99);
        if (pick < 35) f = grow ? FN_APPEND : FN_DELETE;
        else if (pick < 55) f = FN_READ;
        else if (pick < 75) f = FN_FIND;
        else if (pick < 95) f = FN_NEXT;
        else f = grow ? FN_DELETE : FN_APPEND;
        if ((f == FN_FIND || f == FN_NEXT) && list_len > 0 && $urandom_range(0, 4) != 0)
          v = list_model[$urandom_range(0, list_len - 1)];
        else v = pick_value();
        roll = $urandom_range(0, 19);
        if (list_len > 0 && roll < 17) p = POS_W'($urandom_range(1, list_len));
        else if (roll < 18) p = '0;
        else if (roll < 19) p = POS_W'(list_len + 1);
        else p = POS_W'($urandom_range(0, POS_TOP));
      end
      send_req(f, v, p);
    end
  endtask

  task automatic finish_run();
    int unused;
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    unused = 0;
    for (int f = FN_NEXT + 1; f <= FN_TOP_CODE; f++) unused += func_count[f];
    $display("covered %0d requests: %0d append, %0d delete, %0d read, %0d find, %0d next, %0d unused",
             req_count, func_count[FN_APPEND], func_count[FN_DELETE], func_count[FN_READ],
             func_count[FN_FIND], func_count[FN_NEXT], unused);
    $display("checked %0d results, longest list %0d of %0d, long output stall included",
             rsp_count, peak_len, LIST_DEPTH);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  endtask

  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.func          <= FN_APPEND;
    req_ch.element_value <= '0;
    req_ch.position      <= '0;
    rsp_ch.ready         <= 1'b0;
    list_len       = 0;
    error_count    = 0;
    req_count      = 0;
    rsp_count      = 0;
    peak_len       = 0;
    hold_req       = 0;
    hold_active    = 1'b0;
    sender_gaps_on = 1'b1;
    burst_left     = 1;
    foreach (func_count[i]) func_count[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_ends_and_keys();
    test_unused_codes();
    test_full_store();
    test_output_backpressure();
    test_random_traffic();
    finish_run();
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/olse_pkg.sv
rtl/olse_req_if.sv
rtl/olse_rsp_if.sv
rtl/olse_ram.sv
rtl/ordered_list_store_engine_core.sv
tb/ordered_list_store_engine_core_tb.sv
